[sv/date_range_walker_unit_defines.svh]
// Assertion shorthands for the date range walker.
`ifndef DATE_RANGE_WALKER_UNIT_DEFINES_SVH
`define DATE_RANGE_WALKER_UNIT_DEFINES_SVH

// same-cycle implication
`define DRW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("date walker check failed");

// next-cycle implication
`define DRW_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("date walker check failed");

`endif

[sv/drw_pkg.sv]
package drw_pkg;

   localparam int YEAR_W     = 12;
   localparam int MONTH_W    = 4;
   localparam int DAY_W      = 5;
   localparam int WD_W       = 3;
   localparam int STATUS_W   = 2;
   localparam int DATE_W     = YEAR_W + MONTH_W + DAY_W;
   // whole bytes
   localparam int REQ_DATA_W = ((2 * DATE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((DATE_W + WD_W + 7) / 8) * 8;
   localparam int SUM_W      = 5;

   localparam logic [YEAR_W-1:0] EPOCH_YEAR = YEAR_W'(1970);

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_IN_RANGE = 2'd0,
      ST_LAST     = 2'd1,
      ST_DONE     = 2'd2,
      ST_BAD      = 2'd3
   } status_type;

   // year in the top bits, so a plain compare orders dates
   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   function automatic logic date_ok(input date_type d);
      logic ok;
      ok = (d.month >= MONTH_W'(1)) && (d.month <= MONTH_W'(12)) &&
           (d.day != DAY_W'(0)) &&
           !((d.month == MONTH_W'(2)) && (d.day > DAY_W'(29))) &&
           (d.year >= EPOCH_YEAR);
      return ok;
   endfunction

   // (day - 1) mod 7 for day 1..31
   function automatic logic [WD_W-1:0] day_mod7(input logic [DAY_W-1:0] day);
      logic [DAY_W-1:0] v;
      logic [DAY_W-1:0] r;
      v = day - DAY_W'(1);
      if (v >= DAY_W'(28))      r = v - DAY_W'(28);
      else if (v >= DAY_W'(21)) r = v - DAY_W'(21);
      else if (v >= DAY_W'(14)) r = v - DAY_W'(14);
      else if (v >= DAY_W'(7))  r = v - DAY_W'(7);
      else                      r = v;
      return r[WD_W-1:0];
   endfunction

   // days before the month (common year), mod 7
   function automatic logic [WD_W-1:0] month_mod7(input logic [MONTH_W-1:0] m);
      logic [WD_W-1:0] r;
      case (m)
         4'd1:    r = 3'd0;
         4'd2:    r = 3'd3;
         4'd3:    r = 3'd3;
         4'd4:    r = 3'd6;
         4'd5:    r = 3'd1;
         4'd6:    r = 3'd4;
         4'd7:    r = 3'd6;
         4'd8:    r = 3'd2;
         4'd9:    r = 3'd5;
         4'd10:   r = 3'd0;
         4'd11:   r = 3'd3;
         4'd12:   r = 3'd5;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

[sv/drw_mod7.sv]
module drw_mod7 (
   input  logic [drw_pkg::SUM_W-1:0] sum_i,
   output logic [drw_pkg::WD_W-1:0]  rem_o
);

   logic [drw_pkg::SUM_W-1:0] r;

   // operand stays below 21
   always_comb begin
      if (sum_i >= drw_pkg::SUM_W'(14))     r = sum_i - drw_pkg::SUM_W'(14);
      else if (sum_i >= drw_pkg::SUM_W'(7)) r = sum_i - drw_pkg::SUM_W'(7);
      else                                  r = sum_i;
   end

   assign rem_o = r[drw_pkg::WD_W-1:0];

endmodule

[sv/drw_step.sv]
module drw_step (
   input  drw_pkg::date_type date_i,
   output drw_pkg::date_type date_o,
   output logic              wrap_o
);

   logic [drw_pkg::DAY_W-1:0] len;
   logic [drw_pkg::DAY_W:0]   day_inc;

   always_comb begin
      if (date_i.month == drw_pkg::MONTH_W'(2))
         len = drw_pkg::DAY_W'(28) + drw_pkg::DAY_W'(date_i.year[1:0] == 2'b00);
      else if ((date_i.month[0] && date_i.month <= drw_pkg::MONTH_W'(7)) ||
               (!date_i.month[0] && date_i.month >= drw_pkg::MONTH_W'(8)))
         len = drw_pkg::DAY_W'(31);
      else
         len = drw_pkg::DAY_W'(30);

      day_inc = {1'b0, date_i.day} + (drw_pkg::DAY_W+1)'(1);
      date_o  = date_i;
      wrap_o  = 1'b0;
      if (day_inc > {1'b0, len}) begin
         date_o.day = drw_pkg::DAY_W'(1);
         if (date_i.month >= drw_pkg::MONTH_W'(12)) begin
            date_o.month = drw_pkg::MONTH_W'(1);
            date_o.year  = date_i.year + drw_pkg::YEAR_W'(1);
            wrap_o       = &date_i.year;
         end else begin
            date_o.month = date_i.month + drw_pkg::MONTH_W'(1);
         end
      end else begin
         date_o.day = day_inc[drw_pkg::DAY_W-1:0];
      end
   end

endmodule

[sv/date_range_walker_unit.sv]
// Date range walker. A load item (req_tuser = 0) carries two dates; both must
// have month 1..12, day 1..31, February day at most 29 and year 1970 or later,
// else one result with status 3 and all-zero data comes back and nothing
// changes. On a good load the earlier date becomes the current date, the later
// one the end date, and the weekday of the start is built by walking the years
// from 1970 one per cycle through a shared mod-7 adder, and no new item is
// taken until its result is registered. An advance item (req_tuser = 1)
// steps one calendar day and, unless the result output stalls, may be followed
// by another item in the next cycle. Every item gives exactly one result:
// status 0 in range, 1 on the end date, 2 once past the end (or with no range
// loaded), 3 for a rejected load. Every fourth year is taken as a leap year.
module date_range_walker_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [4:0] first_day, [8:5] first_month, [20:9] first_year,
   // [25:21] second_day, [29:26] second_month, [41:30] second_year, rest zero
   input  logic [drw_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] operation
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [4:0] date_day, [8:5] date_month, [20:9] date_year, [23:21] weekday
   output logic [drw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [drw_pkg::STATUS_W-1:0]   rsp_tuser
);

   typedef enum logic [1:0] {
      S_IDLE  = 2'b01,   // taking items
      S_YEARS = 2'b10    // weekday walk over years
   } state_type;

   state_type                     state_ff, state_in;
   drw_pkg::date_type             cur_ff, cur_in;
   drw_pkg::date_type             stop_ff, stop_in;
   logic [drw_pkg::WD_W-1:0]      wd_ff, wd_in;
   logic                          active_ff, active_in;
   logic [drw_pkg::YEAR_W-1:0]    yr_ff, yr_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   drw_pkg::status_type           rsp_status_ff, rsp_status_in;
   drw_pkg::date_type             rsp_date_ff, rsp_date_in;
   logic [drw_pkg::WD_W-1:0]      rsp_wd_ff, rsp_wd_in;

   drw_pkg::date_type             first, second, lo, hi;
   drw_pkg::op_type               op;
   logic                          ok1, ok2, swap, out_free, take, year_done;
   logic [drw_pkg::SUM_W-1:0]     m7_sum;
   logic [drw_pkg::WD_W-1:0]      m7_rem;
   drw_pkg::date_type             step_date;
   logic                          step_wrap;

   // ---- load decode ----
   assign first  = drw_pkg::date_type'(req_tdata[drw_pkg::DATE_W-1:0]);
   assign second = drw_pkg::date_type'(req_tdata[2*drw_pkg::DATE_W-1:drw_pkg::DATE_W]);
   assign op     = drw_pkg::op_type'(req_tuser);
   assign ok1    = drw_pkg::date_ok(first);
   assign ok2    = drw_pkg::date_ok(second);
   assign swap   = first > second;
   assign lo     = swap ? second : first;
   assign hi     = swap ? first : second;

   // output register frees up in the same cycle it is taken
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign take       = req_tvalid && req_tready;
   assign year_done  = yr_ff == cur_ff.year;

   // ---- shared mod-7 adder operand ----
   always_comb begin
      case (state_ff)
         S_IDLE: begin
            if (op == drw_pkg::OP_LOAD)
               // day and month part of the start date, plus leap day
               m7_sum = drw_pkg::SUM_W'(drw_pkg::day_mod7(lo.day)) +
                        drw_pkg::SUM_W'(drw_pkg::month_mod7(lo.month)) +
                        drw_pkg::SUM_W'((lo.year[1:0] == 2'b00) &&
                                        (lo.month > drw_pkg::MONTH_W'(2)));
            else
               m7_sum = drw_pkg::SUM_W'(wd_ff) + drw_pkg::SUM_W'(1);
         end
         S_YEARS: begin
            // 365 = 1 mod 7, 366 = 2 mod 7
            m7_sum = drw_pkg::SUM_W'(wd_ff) + drw_pkg::SUM_W'(1) +
                     drw_pkg::SUM_W'(yr_ff[1:0] == 2'b00);
         end
         default: m7_sum = '0;
      endcase
   end

   drw_mod7 u_mod7 (
      .sum_i (m7_sum),
      .rem_o (m7_rem)
   );

   drw_step u_step (
      .date_i (cur_ff),
      .date_o (step_date),
      .wrap_o (step_wrap)
   );

   // ---- sequencer ----
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      stop_in       = stop_ff;
      wd_in         = wd_ff;
      active_in     = active_ff;
      yr_in         = yr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_date_in   = rsp_date_ff;
      rsp_wd_in     = rsp_wd_ff;

      case (state_ff)
         S_IDLE: begin
            if (take) begin
               case (op)
                  drw_pkg::OP_LOAD: begin
                     if (!(ok1 && ok2)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = drw_pkg::ST_BAD;
                        rsp_date_in   = '0;
                        rsp_wd_in     = '0;
                     end else begin
                        cur_in    = lo;
                        stop_in   = hi;
                        wd_in     = m7_rem;
                        active_in = 1'b1;
                        yr_in     = drw_pkg::EPOCH_YEAR;
                        state_in  = S_YEARS;
                     end
                  end
                  drw_pkg::OP_ADVANCE: begin
                     rsp_valid_in = 1'b1;
                     if (!active_ff) begin
                        // no range: report held date
                        rsp_status_in = drw_pkg::ST_DONE;
                        rsp_date_in   = cur_ff;
                        rsp_wd_in     = wd_ff;
                     end else begin
                        cur_in      = step_date;
                        wd_in       = m7_rem;
                        rsp_date_in = step_date;
                        rsp_wd_in   = m7_rem;
                        if (step_wrap || step_date > stop_ff) begin
                           rsp_status_in = drw_pkg::ST_DONE;
                           active_in     = 1'b0;
                        end else if (step_date == stop_ff) begin
                           rsp_status_in = drw_pkg::ST_LAST;
                        end else begin
                           rsp_status_in = drw_pkg::ST_IN_RANGE;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_YEARS: begin
            if (year_done) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = (cur_ff == stop_ff) ? drw_pkg::ST_LAST
                                                      : drw_pkg::ST_IN_RANGE;
                  rsp_date_in   = cur_ff;
                  rsp_wd_in     = wd_ff;
                  state_in      = S_IDLE;
               end
            end else begin
               wd_in = m7_rem;
               yr_in = yr_ff + drw_pkg::YEAR_W'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '{year: drw_pkg::EPOCH_YEAR, month: drw_pkg::MONTH_W'(1),
                           day: drw_pkg::DAY_W'(1)};
         stop_ff      <= '{year: drw_pkg::EPOCH_YEAR, month: drw_pkg::MONTH_W'(1),
                           day: drw_pkg::DAY_W'(1)};
         wd_ff        <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         stop_ff      <= stop_in;
         wd_ff        <= wd_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      yr_ff         <= yr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_date_ff   <= rsp_date_in;
      rsp_wd_ff     <= rsp_wd_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = drw_pkg::RSP_DATA_W'({rsp_wd_ff, rsp_date_ff});

endmodule

[sv/drw_checker.sv]
`include "date_range_walker_unit_defines.svh"

module drw_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [drw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [drw_pkg::STATUS_W-1:0]   rsp_tuser
);

   logic                        rsp_stall;
   logic                        rsp_good;
   logic [drw_pkg::DAY_W-1:0]   rsp_day;
   logic [drw_pkg::MONTH_W-1:0] rsp_month;
   logic [drw_pkg::WD_W-1:0]    rsp_wd;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_good  = rsp_tvalid && (rsp_tuser != drw_pkg::ST_BAD);
   assign rsp_day   = rsp_tdata[drw_pkg::DAY_W-1:0];
   assign rsp_month = rsp_tdata[drw_pkg::DAY_W+drw_pkg::MONTH_W-1:drw_pkg::DAY_W];
   assign rsp_wd    = rsp_tdata[drw_pkg::DATE_W+drw_pkg::WD_W-1:drw_pkg::DATE_W];

   // stalled result holds
   `DRW_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // rejected load carries no date
   `DRW_ASSERT_IMP(a_bad_zero, clock, reset, rsp_tvalid && rsp_tuser == drw_pkg::ST_BAD, rsp_tdata == '0)

   // weekday in 0..6
   `DRW_ASSERT_IMP(a_wd_range, clock, reset, rsp_tvalid, !(&rsp_wd))

   // reported dates are real calendar positions
   `DRW_ASSERT_IMP(a_date_nz, clock, reset, rsp_good, rsp_day != '0 && rsp_month != '0 && rsp_month <= 4'd12)

endmodule

bind date_range_walker_unit drw_checker u_drw_checker (.*);
